// ----- hdl/tppfl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tppfl_pkg
// Shared types, codes and default sizes for the two-pool page free list.
// ----------------------------------------------------------------------------
package tppfl_pkg;

    localparam int SMALL_DEPTH_DEF     = 65536;
    localparam int HUGE_DEPTH_DEF      = 64;
    localparam int PAGE_SHIFT_DEF      = 12;
    localparam int HUGE_PAGE_SHIFT_DEF = 22;

    localparam int ADDR_W = 32;

    // request opcodes
    localparam logic [1:0] OP_ALLOC_SMALL = 2'd0;
    localparam logic [1:0] OP_FREE_SMALL  = 2'd1;
    localparam logic [1:0] OP_ALLOC_HUGE  = 2'd2;
    localparam logic [1:0] OP_FREE_HUGE   = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_KERNEL_END = 2'd0;
    localparam logic [1:0] REG_SMALL_TOP  = 2'd1;
    localparam logic [1:0] REG_HUGE_START = 2'd2;
    localparam logic [1:0] REG_HUGE_END   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the request transaction
        logic exec;   // check, push or pop
    } dp_cmd_t;

endpackage : tppfl_pkg
`default_nettype wire

// ----- hdl/tppfl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tppfl_ctrl
// Sequencer: takes one request, runs it through the datapath, holds the
// response until it is taken.
// ----------------------------------------------------------------------------
module tppfl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tppfl_pkg::dp_cmd_t     cmd
);

    tppfl_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tppfl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            tppfl_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = tppfl_pkg::S_EXEC;
                end
            end
            tppfl_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = tppfl_pkg::S_RESP;
            end
            tppfl_pkg::S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = tppfl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tppfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule : tppfl_ctrl
`default_nettype wire

// ----- hdl/tppfl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tppfl_dp
// Datapath: bound registers, address checks, the two frame stacks and their
// counts, and the response registers.
// ----------------------------------------------------------------------------
module tppfl_dp #(
    parameter int SMALL_DEPTH     = tppfl_pkg::SMALL_DEPTH_DEF,
    parameter int HUGE_DEPTH      = tppfl_pkg::HUGE_DEPTH_DEF,
    parameter int PAGE_SHIFT      = tppfl_pkg::PAGE_SHIFT_DEF,
    parameter int HUGE_PAGE_SHIFT = tppfl_pkg::HUGE_PAGE_SHIFT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [tppfl_pkg::ADDR_W-1:0]   cfg_wr_data,
    input  wire tppfl_pkg::dp_cmd_t             cmd,
    input  wire logic [1:0]                     s_opcode,
    input  wire logic [tppfl_pkg::ADDR_W-1:0]   s_page_addr,
    output logic [tppfl_pkg::ADDR_W-1:0]        m_result_addr,
    output logic [1:0]                          m_status
);

    localparam int AW       = tppfl_pkg::ADDR_W;
    localparam int SMALL_FW = AW - PAGE_SHIFT;
    localparam int HUGE_FW  = AW - HUGE_PAGE_SHIFT;
    localparam int SMALL_IW = $clog2(SMALL_DEPTH);
    localparam int HUGE_IW  = $clog2(HUGE_DEPTH);
    localparam int SMALL_CW = $clog2(SMALL_DEPTH + 1);
    localparam int HUGE_CW  = $clog2(HUGE_DEPTH + 1);
    localparam logic [AW:0] HUGE_SIZE = (AW+1)'(1) << HUGE_PAGE_SHIFT;

    // bound registers
    logic [AW-1:0] kernel_end_reg, small_top_reg, huge_start_reg, huge_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_end_reg <= '0;
            small_top_reg  <= '0;
            huge_start_reg <= '0;
            huge_end_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tppfl_pkg::REG_KERNEL_END: kernel_end_reg <= cfg_wr_data;
                tppfl_pkg::REG_SMALL_TOP:  small_top_reg  <= cfg_wr_data;
                tppfl_pkg::REG_HUGE_START: huge_start_reg <= cfg_wr_data;
                tppfl_pkg::REG_HUGE_END:   huge_end_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // captured request
    logic [1:0]    op_reg;
    logic [AW-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            addr_reg <= s_page_addr;
        end
    end

    logic [SMALL_CW-1:0] small_cnt_reg, small_cnt_next;
    logic [HUGE_CW-1:0]  huge_cnt_reg, huge_cnt_next;
    logic [SMALL_CW-1:0] small_cnt_dec;
    logic [HUGE_CW-1:0]  huge_cnt_dec;
    logic                small_ok, huge_ok;
    logic                small_push, small_pop, huge_push, huge_pop;
    logic [1:0]          status_next;

    assign small_cnt_dec = small_cnt_reg - SMALL_CW'(1);
    assign huge_cnt_dec  = huge_cnt_reg - HUGE_CW'(1);

    assign small_ok = (addr_reg[PAGE_SHIFT-1:0] == '0)
                   && (addr_reg >= kernel_end_reg)
                   && (addr_reg < small_top_reg);
    // huge page end computed one bit wider so it cannot wrap
    assign huge_ok  = (addr_reg[HUGE_PAGE_SHIFT-1:0] == '0)
                   && (addr_reg >= huge_start_reg)
                   && (({1'b0, addr_reg} + HUGE_SIZE) <= {1'b0, huge_end_reg});

    always_comb begin
        small_push     = 1'b0;
        small_pop      = 1'b0;
        huge_push      = 1'b0;
        huge_pop       = 1'b0;
        status_next    = tppfl_pkg::ST_OK;
        small_cnt_next = small_cnt_reg;
        huge_cnt_next  = huge_cnt_reg;
        case (op_reg)
            tppfl_pkg::OP_ALLOC_SMALL: begin
                if (small_cnt_reg == '0) begin
                    status_next = tppfl_pkg::ST_EMPTY;
                end else begin
                    small_pop      = 1'b1;
                    small_cnt_next = small_cnt_dec;
                end
            end
            tppfl_pkg::OP_FREE_SMALL: begin
                if (!small_ok) begin
                    status_next = tppfl_pkg::ST_INVALID;
                end else if (small_cnt_reg == SMALL_CW'(SMALL_DEPTH)) begin
                    status_next = tppfl_pkg::ST_FULL;
                end else begin
                    small_push     = 1'b1;
                    small_cnt_next = small_cnt_reg + SMALL_CW'(1);
                end
            end
            tppfl_pkg::OP_ALLOC_HUGE: begin
                if (huge_cnt_reg == '0) begin
                    status_next = tppfl_pkg::ST_EMPTY;
                end else begin
                    huge_pop      = 1'b1;
                    huge_cnt_next = huge_cnt_dec;
                end
            end
            tppfl_pkg::OP_FREE_HUGE: begin
                if (!huge_ok) begin
                    status_next = tppfl_pkg::ST_INVALID;
                end else if (huge_cnt_reg == HUGE_CW'(HUGE_DEPTH)) begin
                    status_next = tppfl_pkg::ST_FULL;
                end else begin
                    huge_push     = 1'b1;
                    huge_cnt_next = huge_cnt_reg + HUGE_CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_cnt_reg <= '0;
            huge_cnt_reg  <= '0;
        end else if (cmd.exec) begin
            small_cnt_reg <= small_cnt_next;
            huge_cnt_reg  <= huge_cnt_next;
        end
    end

    // frame stacks, registered read ports
    logic [SMALL_FW-1:0] small_mem [SMALL_DEPTH];
    logic [HUGE_FW-1:0]  huge_mem  [HUGE_DEPTH];
    logic [SMALL_FW-1:0] small_rd_reg;
    logic [HUGE_FW-1:0]  huge_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec && small_push) begin
            small_mem[small_cnt_reg[SMALL_IW-1:0]] <= addr_reg[AW-1:PAGE_SHIFT];
        end
        if (cmd.exec && small_pop) begin
            small_rd_reg <= small_mem[small_cnt_dec[SMALL_IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && huge_push) begin
            huge_mem[huge_cnt_reg[HUGE_IW-1:0]] <= addr_reg[AW-1:HUGE_PAGE_SHIFT];
        end
        if (cmd.exec && huge_pop) begin
            huge_rd_reg <= huge_mem[huge_cnt_dec[HUGE_IW-1:0]];
        end
    end

    // response
    logic [1:0] status_reg;
    logic       pop_small_reg, pop_huge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= tppfl_pkg::ST_OK;
            pop_small_reg <= 1'b0;
            pop_huge_reg  <= 1'b0;
        end else if (cmd.exec) begin
            status_reg    <= status_next;
            pop_small_reg <= small_pop;
            pop_huge_reg  <= huge_pop;
        end
    end

    always_comb begin
        if (pop_small_reg) begin
            m_result_addr = {small_rd_reg, {PAGE_SHIFT{1'b0}}};
        end else if (pop_huge_reg) begin
            m_result_addr = {huge_rd_reg, {HUGE_PAGE_SHIFT{1'b0}}};
        end else begin
            m_result_addr = '0;
        end
    end

    assign m_status = status_reg;

endmodule : tppfl_dp
`default_nettype wire

// ----- hdl/two_pool_page_free_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_pool_page_free_list
// LIFO free lists of small and huge page frames with address checking.
// After a request is accepted the controller goes to S_EXEC, where the
// datapath checks and pushes or pops, then to S_RESP, where the registered
// response is held valid until taken. A new request is accepted only once
// the response is taken; the stack memory's registered read port is why S_EXEC is a step.
// Reset: both pools empty, bound registers zero; no clearing pass needed.
// ----------------------------------------------------------------------------
module two_pool_page_free_list #(
    parameter int SMALL_DEPTH     = tppfl_pkg::SMALL_DEPTH_DEF,
    parameter int HUGE_DEPTH      = tppfl_pkg::HUGE_DEPTH_DEF,
    parameter int PAGE_SHIFT      = tppfl_pkg::PAGE_SHIFT_DEF,
    parameter int HUGE_PAGE_SHIFT = tppfl_pkg::HUGE_PAGE_SHIFT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [tppfl_pkg::ADDR_W-1:0]   cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_opcode,
    input  wire logic [tppfl_pkg::ADDR_W-1:0]   s_page_addr,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tppfl_pkg::ADDR_W-1:0]        m_result_addr,
    output logic [1:0]                          m_status
);

    tppfl_pkg::dp_cmd_t cmd;

    tppfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tppfl_dp #(
        .SMALL_DEPTH     (SMALL_DEPTH),
        .HUGE_DEPTH      (HUGE_DEPTH),
        .PAGE_SHIFT      (PAGE_SHIFT),
        .HUGE_PAGE_SHIFT (HUGE_PAGE_SHIFT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .s_opcode      (s_opcode),
        .s_page_addr   (s_page_addr),
        .m_result_addr (m_result_addr),
        .m_status      (m_status)
    );

endmodule : two_pool_page_free_list
`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_pool_page_free_list. A mirror of both page
// stacks and the bound registers predicts every response; responses are
// matched in order. Directed corner requests, a fill-to-full run of the huge
// pool, then random traffic under changing bounds and handshake idling.
// ----------------------------------------------------------------------------
module tb;
    import tppfl_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SMALL_FW      = ADDR_W - PAGE_SHIFT_DEF;
    localparam int HUGE_FW       = ADDR_W - HUGE_PAGE_SHIFT_DEF;

    class page_pool_mirror;
        typedef struct packed {
            logic [ADDR_W-1:0] addr;
            logic [1:0]        status;
        } reply_t;

        logic [ADDR_W-1:0] kernel_end = '0;
        logic [ADDR_W-1:0] small_top  = '0;
        logic [ADDR_W-1:0] huge_start = '0;
        logic [ADDR_W-1:0] huge_end   = '0;

        bit [SMALL_FW-1:0] small_frames [SMALL_DEPTH_DEF];
        bit [HUGE_FW-1:0]  huge_frames  [HUGE_DEPTH_DEF];
        int unsigned small_used = 0;
        int unsigned huge_used  = 0;

        reply_t due_replies [$];
        int unsigned faults  = 0;
        int unsigned checked = 0;

        function void set_reg(logic [1:0] idx, logic [ADDR_W-1:0] val);
            case (idx)
                REG_KERNEL_END: kernel_end = val;
                REG_SMALL_TOP:  small_top  = val;
                REG_HUGE_START: huge_start = val;
                REG_HUGE_END:   huge_end   = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return due_replies.size();
        endfunction

        function void note_request(logic [1:0] op, logic [ADDR_W-1:0] addr);
            reply_t r;
            logic [ADDR_W:0] huge_limit;
            r.addr   = '0;
            r.status = ST_OK;
            // end of the huge page, no wrap
            huge_limit = {1'b0, addr} + ((ADDR_W+1)'(1) << HUGE_PAGE_SHIFT_DEF);
            case (op)
                OP_ALLOC_SMALL: begin
                    if (small_used == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        small_used--;
                        r.addr = ADDR_W'(small_frames[small_used]) << PAGE_SHIFT_DEF;
                    end
                end
                OP_FREE_SMALL: begin
                    if (addr[PAGE_SHIFT_DEF-1:0] != 0 || addr < kernel_end ||
                        addr >= small_top) begin
                        r.status = ST_INVALID;
                    end else if (small_used == SMALL_DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        small_frames[small_used] = SMALL_FW'(addr >> PAGE_SHIFT_DEF);
                        small_used++;
                    end
                end
                OP_ALLOC_HUGE: begin
                    if (huge_used == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        huge_used--;
                        r.addr = ADDR_W'(huge_frames[huge_used]) << HUGE_PAGE_SHIFT_DEF;
                    end
                end
                default: begin
                    if (addr[HUGE_PAGE_SHIFT_DEF-1:0] != 0 || addr < huge_start ||
                        huge_limit > {1'b0, huge_end}) begin
                        r.status = ST_INVALID;
                    end else if (huge_used == HUGE_DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        huge_frames[huge_used] = HUGE_FW'(addr >> HUGE_PAGE_SHIFT_DEF);
                        huge_used++;
                    end
                end
            endcase
            due_replies.push_back(r);
        endfunction

        task report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
            faults++;
            $display("response %0d: %s got %h want %h", checked, what, got, want);
        endtask

        task check_result(logic [ADDR_W-1:0] addr, logic [1:0] status);
            reply_t r;
            if (due_replies.size() == 0) begin
                report("unexpected response, addr", addr, '0);
            end else begin
                r = due_replies.pop_front();
                if (addr !== r.addr)
                    report("result_addr", addr, r.addr);
                if (status !== r.status)
                    report("status", ADDR_W'(status), ADDR_W'(r.status));
            end
            checked++;
        endtask
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [1:0]        cfg_index   = REG_KERNEL_END;
    logic [ADDR_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode    = OP_ALLOC_SMALL;
    logic [ADDR_W-1:0] s_page_addr = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [ADDR_W-1:0] m_result_addr;
    logic [1:0]        m_status;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned quiet_cycles  = 0;
    page_pool_mirror mirror;

    two_pool_page_free_list uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_page_addr   (s_page_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_addr (m_result_addr),
        .m_status      (m_status)
    );

    always #1 aclk = ~aclk;

    // response side: check, then pick next cycle's ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                mirror.check_result(m_result_addr, m_status);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("two_pool_page_free_list: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_page_addr <= addr;
        do @(posedge aclk); while (!s_ready);
        mirror.note_request(op, addr);
    endtask

    // drop valid and wait out every owed response plus the pipeline tail
    task automatic settle();
        s_valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        mirror.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic write_bounds(input logic [ADDR_W-1:0] k, s, hs, he);
        write_reg(REG_KERNEL_END, k);
        write_reg(REG_SMALL_TOP, s);
        write_reg(REG_HUGE_START, hs);
        write_reg(REG_HUGE_END, he);
        cfg_wr_en <= 1'b0;
    endtask

    // random aligned address that passes the current bounds; 0 if none exists
    function automatic bit pick_free_addr(input bit huge, output logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0] lo, hi;
        int unsigned sh;
        addr = $urandom;
        sh = huge ? HUGE_PAGE_SHIFT_DEF : PAGE_SHIFT_DEF;
        if (huge) begin
            if (mirror.huge_end < (ADDR_W'(1) << HUGE_PAGE_SHIFT_DEF))
                return 0;
            lo = {1'b0, mirror.huge_start} + (((ADDR_W+1)'(1) << sh) - 1);
            hi = {1'b0, mirror.huge_end} - ((ADDR_W+1)'(1) << sh);
        end else begin
            if (mirror.small_top == 0)
                return 0;
            lo = {1'b0, mirror.kernel_end} + (((ADDR_W+1)'(1) << sh) - 1);
            hi = {1'b0, mirror.small_top} - 1;
        end
        lo = lo >> sh;
        hi = hi >> sh;
        if (lo > hi)
            return 0;
        addr = ADDR_W'($urandom_range(32'(hi), 32'(lo))) << sh;
        return 1;
    endfunction

    task automatic random_request(output logic [1:0] op, output logic [ADDR_W-1:0] addr);
        int unsigned roll;
        logic [ADDR_W-1:0] base, step;
        roll = $urandom_range(99);
        addr = $urandom;
        if (roll < 40) begin
            op = $urandom_range(1) ? OP_ALLOC_HUGE : OP_ALLOC_SMALL;
        end else if (roll < 85) begin
            op = $urandom_range(1) ? OP_FREE_HUGE : OP_FREE_SMALL;
            void'(pick_free_addr(op == OP_FREE_HUGE, addr));
        end else if (roll < 93) begin
            op = 2'($urandom);
        end else begin
            // probe right around one of the bounds
            op = $urandom_range(1) ? OP_FREE_HUGE : OP_FREE_SMALL;
            step = (op == OP_FREE_HUGE) ? (ADDR_W'(1) << HUGE_PAGE_SHIFT_DEF)
                                         : (ADDR_W'(1) << PAGE_SHIFT_DEF);
            case ($urandom_range(3))
                0:       base = mirror.kernel_end;
                1:       base = mirror.small_top;
                2:       base = mirror.huge_start;
                default: base = mirror.huge_end - step;
            endcase
            addr = base & ~(step - 1);
            case ($urandom_range(4))
                0:       addr = base;
                1:       addr = addr - step;
                2:       addr = addr + step;
                3:       addr = base - 1;
                default: ;
            endcase
        end
    endtask

    task automatic fill_and_drain(input bit huge);
        logic [ADDR_W-1:0] addr;
        logic [1:0] op_free, op_alloc;
        int unsigned depth;
        op_free  = huge ? OP_FREE_HUGE : OP_FREE_SMALL;
        op_alloc = huge ? OP_ALLOC_HUGE : OP_ALLOC_SMALL;
        depth    = huge ? HUGE_DEPTH_DEF : SMALL_DEPTH_DEF;
        while ((huge ? mirror.huge_used : mirror.small_used) < depth) begin
            void'(pick_free_addr(huge, addr));
            send_req(op_free, addr);
        end
        void'(pick_free_addr(huge, addr));
        send_req(op_free, addr);
        // bad address on a full pool: address check wins
        send_req(op_free, 32'h0000_0001);
        while ((huge ? mirror.huge_used : mirror.small_used) != 0)
            send_req(op_alloc, $urandom);
        send_req(op_alloc, $urandom);
        settle();
    endtask

    initial begin
        logic [1:0] op;
        logic [ADDR_W-1:0] addr, a, b, hs;
        logic [ADDR_W:0] he;
        int n;

        mirror = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 71;

        // all bounds at zero: nothing can be freed
        send_req(OP_ALLOC_SMALL, 32'hFFFF_FFFF);
        send_req(OP_ALLOC_HUGE, 32'h0);
        send_req(OP_FREE_SMALL, 32'h0);
        send_req(OP_FREE_HUGE, 32'h0);
        settle();

        write_bounds(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_req(OP_FREE_SMALL, 32'h0);
        send_req(OP_ALLOC_SMALL, 32'h0);
        send_req(OP_FREE_SMALL, 32'hFFFF_F000);
        send_req(OP_FREE_SMALL, 32'h0000_0001);
        send_req(OP_FREE_SMALL, 32'h0000_0800);
        send_req(OP_ALLOC_SMALL, 32'hFFFF_FFFF);
        send_req(OP_FREE_HUGE, 32'hFFC0_0000);   // would end past 4 GB
        send_req(OP_FREE_HUGE, 32'hFF80_0000);
        send_req(OP_FREE_HUGE, 32'h0);
        send_req(OP_FREE_HUGE, 32'h0020_0000);
        send_req(OP_ALLOC_HUGE, 32'h0);
        send_req(OP_ALLOC_HUGE, 32'h0);
        send_req(OP_ALLOC_HUGE, 32'h0);
        settle();

        write_bounds(32'h0001_0000, 32'h0002_0000, 32'h4000_0000, 32'h4080_0000);
        send_req(OP_FREE_SMALL, 32'h0000_F000);
        send_req(OP_FREE_SMALL, 32'h0001_0000);
        send_req(OP_FREE_SMALL, 32'h0001_F000);
        send_req(OP_FREE_SMALL, 32'h0002_0000);
        send_req(OP_FREE_HUGE, 32'h3FC0_0000);
        send_req(OP_FREE_HUGE, 32'h4000_0000);
        send_req(OP_FREE_HUGE, 32'h4040_0000);   // ends exactly at the bound
        send_req(OP_FREE_HUGE, 32'h4080_0000);
        settle();

        write_bounds(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        fill_and_drain(1'b1);

        for (int seg = 0; seg < 7; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 20;
                recv_idle_pct = 71;
            end else if (seg < 5) begin
                send_idle_pct = 71;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 3) begin
                write_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
            end else if (seg % 2 == 1) begin
                write_bounds(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
            end else begin
                a  = $urandom;
                b  = $urandom;
                hs = $urandom;
                // huge window a few pages long, start usually unaligned
                he = {1'b0, hs} + ($urandom_range(5) << HUGE_PAGE_SHIFT_DEF) +
                     $urandom_range(1);
                if (he[ADDR_W])
                    he = {1'b0, {ADDR_W{1'b1}}};
                write_bounds(a < b ? a : b, a < b ? b : a, hs, he[ADDR_W-1:0]);
            end
            n = (seg == 3) ? 30 : 145;
            repeat (n) begin
                random_request(op, addr);
                send_req(op, addr);
            end
            settle();
        end

        if (mirror.faults == 0)
            $display("two_pool_page_free_list: match");
        else
            $display("two_pool_page_free_list: mismatch");
        $finish;
    end
endmodule
